// ===== rtl/core/pixel_replication_upscaler_defines.svh =====
// ---------------------------------------------------------------------------
// pixel_replication_upscaler_defines.svh
// Assertion macros used by the upscaler emit stage (pru_emit).
// ---------------------------------------------------------------------------
`ifndef PIXEL_REPLICATION_UPSCALER_DEFINES_SVH
`define PIXEL_REPLICATION_UPSCALER_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define PRU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define PRU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	`PRU_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ===== rtl/core/pru_pkg.sv =====
// ---------------------------------------------------------------------------
// pru_pkg
// Sizes, codes and shared types of the pixel replication upscaler.
// ---------------------------------------------------------------------------
package pru_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_SCALE = 8;

	localparam int CHAN_W = 8;
	localparam int PIX_W  = 3 * CHAN_W;
	localparam int SC_W   = 4;     // scale_factor register width
	localparam int LW_W   = 11;    // line_width register width
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = LW_W;

	localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
	localparam int CMP_W  = (COL_W + 1 > LW_W) ? COL_W + 1 : LW_W;
	localparam int RCMP_W = (ROW_W + 1 > SC_W) ? ROW_W + 1 : SC_W;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH = CFG_IDX_W'(1);

	localparam logic [SC_W-1:0] SCALE_RST = SC_W'(2);
	localparam logic [LW_W-1:0] WIDTH_RST = LW_W'(1024);

	typedef enum logic [1:0] {
		PH_LOAD   = 2'b01,
		PH_REPLAY = 2'b10
	} pru_phase_t;

	// One accepted command, as handed from the control unit to the emitter.
	typedef struct packed {
		logic             err;       // command did not fit the phase
		logic             use_ram;   // pixel comes from the line store read
		logic             row_last;  // last pixel of the row
		logic [SC_W-1:0]  n;         // copies to emit, 1..MAX_SCALE
		logic [PIX_W-1:0] pix;       // pixel when use_ram is low
	} pru_item_t;

	// Line store access issued at acceptance.
	typedef struct packed {
		logic             we;
		logic [COL_W-1:0] waddr;
		logic [PIX_W-1:0] wdata;
		logic             re;
		logic [COL_W-1:0] raddr;
	} pru_ram_req_t;

endpackage

// ===== rtl/core/pru_if.sv =====
// ---------------------------------------------------------------------------
// pru_if
// Valid/ready channels of the upscaler: input, result and config write.
// ---------------------------------------------------------------------------
interface pru_in_if;
	logic                       valid;
	logic                       ready;
	logic                       cmd;
	logic [pru_pkg::CHAN_W-1:0] chan0_in;
	logic [pru_pkg::CHAN_W-1:0] chan1_in;
	logic [pru_pkg::CHAN_W-1:0] chan2_in;

	modport source(output valid, cmd, chan0_in, chan1_in, chan2_in, input ready);
	modport sink(input valid, cmd, chan0_in, chan1_in, chan2_in, output ready);
endinterface

interface pru_out_if;
	logic                       valid;
	logic                       ready;
	logic [pru_pkg::CHAN_W-1:0] chan0_out;
	logic [pru_pkg::CHAN_W-1:0] chan1_out;
	logic [pru_pkg::CHAN_W-1:0] chan2_out;
	logic                       row_end;
	logic                       run_last;
	logic                       phase_error;

	modport source(output valid, chan0_out, chan1_out, chan2_out, row_end, run_last,
		phase_error, input ready);
	modport sink(input valid, chan0_out, chan1_out, chan2_out, row_end, run_last,
		phase_error, output ready);
endinterface

interface pru_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pru_pkg::CFG_IDX_W-1:0] index;
	logic [pru_pkg::CFG_DAT_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/pru_ram.sv =====
// ---------------------------------------------------------------------------
// pru_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module pru_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold the last read word while re is low
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/pru_ctrl.sv =====
// ---------------------------------------------------------------------------
// pru_ctrl
// Phase tracking, column counters, config registers and line store access.
// ---------------------------------------------------------------------------
module pru_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	pru_in_if.sink                feed,
	pru_cfg_if.sink               cfg,
	input  logic                  item_ready,
	output pru_pkg::pru_item_t    item,
	output pru_pkg::pru_ram_req_t ram_req
);

	logic [pru_pkg::SC_W-1:0]   scale_q;
	logic [pru_pkg::LW_W-1:0]   width_q;
	pru_pkg::pru_phase_t        phase_q;
	logic [pru_pkg::COL_W-1:0]  load_col_q;
	logic [pru_pkg::COL_W-1:0]  rep_col_q;
	logic [pru_pkg::ROW_W-1:0]  rep_row_q;

	logic [pru_pkg::SC_W-1:0]   s_eff;
	logic [pru_pkg::CMP_W-1:0]  w_eff;
	logic [pru_pkg::CMP_W-1:0]  w_m1;
	logic [pru_pkg::RCMP_W-1:0] row_next;
	logic [pru_pkg::RCMP_W-1:0] s_m1;
	logic                       bad;
	logic                       load_last;
	logic                       rep_last;
	logic                       accept;
	logic                       go;

	assign cfg.ready  = 1'b1;
	assign feed.ready = item_ready;
	assign accept     = feed.valid && feed.ready;
	assign go         = accept && !bad;

	always_comb begin
		s_eff = scale_q;
		if (scale_q == '0) begin
			s_eff = pru_pkg::SC_W'(1);
		end else if (int'(scale_q) > pru_pkg::MAX_SCALE) begin
			s_eff = pru_pkg::SC_W'(pru_pkg::MAX_SCALE);
		end
		w_eff = pru_pkg::CMP_W'(width_q);
		if (width_q == '0) begin
			w_eff = pru_pkg::CMP_W'(1);
		end else if (int'(width_q) > pru_pkg::MAX_WIDTH) begin
			w_eff = pru_pkg::CMP_W'(pru_pkg::MAX_WIDTH);
		end
		w_m1      = w_eff - pru_pkg::CMP_W'(1);
		load_last = pru_pkg::CMP_W'(load_col_q) >= w_m1;
		rep_last  = pru_pkg::CMP_W'(rep_col_q) >= w_m1;
		row_next  = pru_pkg::RCMP_W'(rep_row_q) + pru_pkg::RCMP_W'(1);
		s_m1      = pru_pkg::RCMP_W'(s_eff) - pru_pkg::RCMP_W'(1);
		bad       = feed.cmd != (phase_q == pru_pkg::PH_REPLAY);

		item.err      = bad;
		item.use_ram  = !bad && feed.cmd;
		item.row_last = !bad && (feed.cmd ? rep_last : load_last);
		item.n        = bad ? pru_pkg::SC_W'(1) : s_eff;
		item.pix      = (bad || feed.cmd) ? '0
			: {feed.chan2_in, feed.chan1_in, feed.chan0_in};

		ram_req.we    = go && !feed.cmd;
		ram_req.waddr = load_col_q;
		ram_req.wdata = {feed.chan2_in, feed.chan1_in, feed.chan0_in};
		ram_req.re    = go && feed.cmd;
		ram_req.raddr = rep_col_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= pru_pkg::SCALE_RST;
			width_q <= pru_pkg::WIDTH_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				pru_pkg::REG_SCALE: scale_q <= cfg.data[pru_pkg::SC_W-1:0];
				pru_pkg::REG_WIDTH: width_q <= cfg.data[pru_pkg::LW_W-1:0];
				default: ;
			endcase
		end
	end

	// Writes and reads of the line store are issued in command order, one per
	// cycle at most, so a replay read always lands after the push that wrote it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= pru_pkg::PH_LOAD;
			load_col_q <= '0;
			rep_col_q  <= '0;
			rep_row_q  <= '0;
		end else if (go) begin
			if (!feed.cmd) begin
				if (load_last) begin
					load_col_q <= '0;
					if (s_eff > pru_pkg::SC_W'(1)) begin
						phase_q   <= pru_pkg::PH_REPLAY;
						rep_col_q <= '0;
						rep_row_q <= '0;
					end
				end else begin
					load_col_q <= load_col_q + pru_pkg::COL_W'(1);
				end
			end else begin
				if (rep_last) begin
					rep_col_q <= '0;
					if (row_next >= s_m1) begin
						phase_q   <= pru_pkg::PH_LOAD;
						rep_row_q <= '0;
					end else begin
						rep_row_q <= row_next[pru_pkg::ROW_W-1:0];
					end
				end else begin
					rep_col_q <= rep_col_q + pru_pkg::COL_W'(1);
				end
			end
		end
	end

endmodule

// ===== rtl/core/pru_emit.sv =====
// ---------------------------------------------------------------------------
// pru_emit
// Replicates each accepted pixel n times into a registered result stage.
// ---------------------------------------------------------------------------
`include "pixel_replication_upscaler_defines.svh"

module pru_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	input  pru_pkg::pru_item_t         item,
	output logic                       item_ready,
	input  logic [pru_pkg::PIX_W-1:0]  ram_rdata,
	pru_out_if.source                  result
);

	logic                       valid_s1;
	pru_pkg::pru_item_t         item_s1;
	logic [pru_pkg::SC_W-1:0]   cnt_q;

	logic                       out_valid_q;
	logic [pru_pkg::PIX_W-1:0]  out_pix_q;
	logic                       out_row_end_q;
	logic                       out_last_q;
	logic                       out_err_q;

	logic                       out_ld;
	logic                       fire;
	logic                       final_copy;
	logic [pru_pkg::PIX_W-1:0]  pix_cur;

	assign out_ld     = !out_valid_q || result.ready;
	assign fire       = valid_s1 && out_ld;
	assign final_copy = cnt_q == (item_s1.n - pru_pkg::SC_W'(1));
	assign item_ready = !valid_s1 || (fire && final_copy);
	assign pix_cur    = item_s1.use_ram ? ram_rdata : item_s1.pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_q    <= '0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
			cnt_q    <= '0;
		end else if (fire && final_copy) begin
			valid_s1 <= 1'b0;
		end else if (fire) begin
			cnt_q <= cnt_q + pru_pkg::SC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ld) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_pix_q     <= pix_cur;
			out_row_end_q <= final_copy && item_s1.row_last;
			out_last_q    <= final_copy;
			out_err_q     <= item_s1.err;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.chan0_out   = out_pix_q[pru_pkg::CHAN_W-1:0];
	assign result.chan1_out   = out_pix_q[2*pru_pkg::CHAN_W-1:pru_pkg::CHAN_W];
	assign result.chan2_out   = out_pix_q[3*pru_pkg::CHAN_W-1:2*pru_pkg::CHAN_W];
	assign result.row_end     = out_row_end_q;
	assign result.run_last    = out_last_q;
	assign result.phase_error = out_err_q;

	`PRU_ASSERT_IMPL(a_cnt_in_run, clk, arst_n, valid_s1, cnt_q < item_s1.n, "copy count past run")
	`PRU_ASSERT_IMPL(a_err_single, clk, arst_n, out_valid_q && out_err_q, out_last_q && !out_row_end_q && (out_pix_q == '0), "error result malformed")
	`PRU_ASSERT_IMPL(a_row_end_last, clk, arst_n, out_valid_q && out_row_end_q, out_last_q, "row end off run end")
	`PRU_ASSERT(a_take_on_finish, clk, arst_n, (valid_s1 && item_ready) |-> (fire && final_copy), "item taken mid run")

endmodule

// ===== rtl/core/pixel_replication_upscaler.sv =====
// ---------------------------------------------------------------------------
// pixel_replication_upscaler
// Integer nearest-neighbor upscaler: each source row is stored in a line
// store and each pixel is replicated in both axes.
// ---------------------------------------------------------------------------
//  port     dir  handshake        payload
//  feed     in   valid/ready      cmd, chan0_in, chan1_in, chan2_in
//  result   out  valid/ready      chan0_out..chan2_out, row_end, run_last,
//                                 phase_error
//  cfg      in   valid/ready(=1)  index, data
//
//  A command yields effective scale_factor results (one for a phase
//  error), one per cycle from the result register while result is ready;
//  the next command is taken in the cycle the last copy moves. Replay
//  reads use the registered line store port, ready in the emit stage.
//  Reset clears counters, returns phase to load and sets scale 2 and
//  width 1024; the line store is not cleared. A stalled result port
//  holds the result register and the emit stage.
// ---------------------------------------------------------------------------
module pixel_replication_upscaler (
	input  logic       clk,
	input  logic       arst_n,
	pru_in_if.sink     feed,
	pru_out_if.source  result,
	pru_cfg_if.sink    cfg
);

	pru_pkg::pru_item_t           item;
	pru_pkg::pru_ram_req_t        ram_req;
	logic                         item_ready;
	logic [pru_pkg::PIX_W-1:0]    ram_rdata;

	pru_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.cfg        (cfg),
		.item_ready (item_ready),
		.item       (item),
		.ram_req    (ram_req)
	);

	pru_ram #(
		.WIDTH (pru_pkg::PIX_W),
		.DEPTH (pru_pkg::MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.re    (ram_req.re),
		.raddr (ram_req.raddr),
		.rdata (ram_rdata)
	);

	pru_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (feed.valid),
		.item       (item),
		.item_ready (item_ready),
		.ram_rdata  (ram_rdata),
		.result     (result)
	);

endmodule
